FILE: rtl/pprs_pkg.sv
// Package with the shared constants and types of the ping-pong sample reorder unit.
package pprs_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FIELD_BITS  = 32;
  localparam int STORE_BITS  = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

  localparam int TILE_W      = 4;
  localparam int BEAT_W      = 3;
  localparam int PAIR_W      = 4;
  localparam int STORE_DEPTH = 512;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int BANK_DEPTH  = STORE_DEPTH / LANES;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int FIFO_DEPTH  = 2;
  localparam int LEVEL_W     = 2;

  localparam logic [TILE_W-1:0] LAST_TILE = TILE_W'(15);
  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(7);

  typedef struct packed {
    logic                  en;
    logic                  half;
    logic [1:0]            group;
    logic                  col_hi;
    logic [3:0]            samp;
    logic [FIELD_BITS-1:0] first;
    logic [FIELD_BITS-1:0] second;
  } pprs_wr_t;

  typedef struct packed {
    logic       en;
    logic       half;
    logic [1:0] group;
    logic [1:0] col;
    logic [2:0] pair;
  } pprs_rd_t;

  typedef struct packed {
    logic              valid;
    logic              col_lo;
    logic [PAIR_W-1:0] pair;
    logic              last;
  } pprs_meta_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               pop;
  } pprs_stat_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] out_even;
    logic [FIELD_BITS-1:0] out_odd;
    logic [PAIR_W-1:0]     pair_position;
    logic                  beat_end;
  } pprs_res_t;

endpackage

FILE: rtl/pprs_in_if.sv
// Request channel carrying one tile's pair of input samples.
interface pprs_in_if;
  import pprs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] sample_first;
  logic [FIELD_BITS-1:0] sample_second;

  modport source (output valid, output sample_first, output sample_second, input ready);
  modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

FILE: rtl/pprs_out_if.sv
// Request channel carrying one reordered output pair.
interface pprs_out_if;
  import pprs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] out_even;
  logic [FIELD_BITS-1:0] out_odd;
  logic [PAIR_W-1:0]     pair_position;
  logic                  beat_end;

  modport source (output valid, output out_even, output out_odd, output pair_position,
                  output beat_end, input ready);
  modport sink   (input valid, input out_even, input out_odd, input pair_position,
                  input beat_end, output ready);
endinterface

FILE: rtl/pprs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pprs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pprs_lane.sv
// One storage lane holding the entries of one column parity and one sample parity.
module pprs_lane (
  input  logic                               clk_i,
  input  logic [pprs_pkg::LANE_W-1:0]        lane_id_i,
  input  pprs_pkg::pprs_wr_t                 wr_i,
  input  pprs_pkg::pprs_rd_t                 rd_i,
  output logic [pprs_pkg::STORE_BITS-1:0]    rdata_o
);
  import pprs_pkg::*;

  logic                  col_par;
  logic                  samp_par;
  logic                  we;
  logic                  re;
  logic [BANK_AW-1:0]    waddr;
  logic [BANK_AW-1:0]    raddr;
  logic [STORE_BITS-1:0] wdata;

  assign col_par  = lane_id_i[1];
  assign samp_par = lane_id_i[0];

  // A pair is written to both column parities at one sample; a read takes
  // both sample parities of one column.
  assign we    = wr_i.en && (wr_i.samp[0] == samp_par);
  assign waddr = {wr_i.half, wr_i.group, wr_i.col_hi, wr_i.samp[3:1]};
  assign wdata = col_par ? wr_i.second[STORE_BITS-1:0] : wr_i.first[STORE_BITS-1:0];

  assign re    = rd_i.en && (rd_i.col[0] == col_par);
  assign raddr = {rd_i.half, rd_i.group, rd_i.col[1], ~rd_i.pair};

  pprs_ram #(
    .WIDTH (STORE_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_o)
  );

endmodule

FILE: rtl/pprs_merge.sv
// Merge stage that picks the even and odd samples from the lanes and queues the result.
module pprs_merge (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic [pprs_pkg::LANES-1:0][pprs_pkg::STORE_BITS-1:0] rdata_i,
  input  pprs_pkg::pprs_meta_t                               meta_i,
  output pprs_pkg::pprs_stat_t                               stat_o,
  pprs_out_if.source                                         out_o
);
  import pprs_pkg::*;

  pprs_res_t          fifo_q [FIFO_DEPTH];
  pprs_res_t          res;
  pprs_res_t          head;
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               push;
  logic               pop;

  always_comb begin
    res.out_even      = FIELD_BITS'(rdata_i[{meta_i.col_lo, 1'b0}]);
    res.out_odd       = FIELD_BITS'(rdata_i[{meta_i.col_lo, 1'b1}]);
    res.pair_position = meta_i.pair;
    res.beat_end      = meta_i.last;
  end

  assign push = meta_i.valid;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    level_d  = level_q + LEVEL_W'(push) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign head = fifo_q[rd_ptr_q];

  assign out_o.valid         = (level_q != '0);
  assign out_o.out_even      = head.out_even;
  assign out_o.out_odd       = head.out_odd;
  assign out_o.pair_position = head.pair_position;
  assign out_o.beat_end      = head.beat_end;

  assign stat_o.level = level_q;
  assign stat_o.pop   = pop;

endmodule

FILE: rtl/ping_pong_sample_reorder_unit.sv
// Top level of the ping-pong sample reorder unit.
// Read data and meta_q are registered; the result then enters the output queue, which offers it.
// Throughput: one request per cycle while ready; each lane RAM takes at most a write and a read.
// The first 128 requests after reset fill the first half and produce no result.
// Reset clears the tile, beat, half and primed state and the output queue, not the store.
module ping_pong_sample_reorder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pprs_in_if.sink    in_i,
  pprs_out_if.source out_o
);
  import pprs_pkg::*;

  logic [TILE_W-1:0]                 tile_q, tile_d;
  logic [BEAT_W-1:0]                 beat_q, beat_d;
  logic                              half_q, half_d;
  logic                              primed_q, primed_d;
  pprs_meta_t                        meta_q, meta_d;
  pprs_wr_t                          wr;
  pprs_rd_t                          rd;
  pprs_stat_t                        stat;
  logic [LANES-1:0][STORE_BITS-1:0]  rdata;
  logic [LEVEL_W-1:0]                occupancy;
  logic                              accept;
  logic                              odd_beat;

  assign occupancy  = stat.level + LEVEL_W'(meta_q.valid) - LEVEL_W'(stat.pop);
  assign in_i.ready = (occupancy < LEVEL_W'(FIFO_DEPTH));
  assign accept     = in_i.valid && in_i.ready;
  assign odd_beat   = beat_q[0];

  always_comb begin
    wr.en     = accept;
    wr.half   = half_q;
    wr.group  = tile_q[3:2];
    wr.col_hi = odd_beat;
    wr.samp   = {~tile_q[1:0], beat_q[2:1]};
    wr.first  = in_i.sample_first;
    wr.second = in_i.sample_second;

    rd.en     = accept && primed_q;
    rd.half   = ~half_q;
    rd.group  = {odd_beat, tile_q[3] ^ odd_beat};
    rd.col    = beat_q[2:1];
    rd.pair   = tile_q[2:0];
  end

  always_comb begin
    tile_d   = tile_q;
    beat_d   = beat_q;
    half_d   = half_q;
    primed_d = primed_q;
    if (accept) begin
      if (tile_q == LAST_TILE) begin
        tile_d = '0;
        if (beat_q == LAST_BEAT) begin
          beat_d   = '0;
          half_d   = ~half_q;
          primed_d = 1'b1;
        end else begin
          beat_d = beat_q + BEAT_W'(1);
        end
      end else begin
        tile_d = tile_q + TILE_W'(1);
      end
    end
  end

  always_comb begin
    meta_d.valid  = rd.en;
    meta_d.col_lo = beat_q[1];
    meta_d.pair   = tile_q;
    meta_d.last   = (tile_q == LAST_TILE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q   <= '0;
      beat_q   <= '0;
      half_q   <= 1'b0;
      primed_q <= 1'b0;
      meta_q   <= '0;
    end else begin
      tile_q   <= tile_d;
      beat_q   <= beat_d;
      half_q   <= half_d;
      primed_q <= primed_d;
      meta_q   <= meta_d;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pprs_lane u_lane (
      .clk_i     (clk_i),
      .lane_id_i (LANE_W'(l)),
      .wr_i      (wr),
      .rd_i      (rd),
      .rdata_o   (rdata[l])
    );
  end

  pprs_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rdata_i (rdata),
    .meta_i  (meta_q),
    .stat_o  (stat),
    .out_o   (out_o)
  );

endmodule

FILE: rtl/pprs_checker.sv
// Port-level checker for the ping-pong sample reorder unit, with its bind statement.
module pprs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [pprs_pkg::FIELD_BITS-1:0]   out_even_i,
  input logic [pprs_pkg::PAIR_W-1:0]       pair_position_i,
  input logic                              beat_end_i
);
  import pprs_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_even_i) && $stable(pair_position_i))
    else $error("Stalled output request changed its payload.");

  // The last pair of a beat is flagged, and only that pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (beat_end_i == (pair_position_i == LAST_TILE)))
    else $error("Beat end flag does not match the pair position.");

  // Whenever a result drains, the unit has room for a new request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |-> in_ready_i)
    else $error("Input stalled although the output drained.");

  // Nothing is offered during reset or in the first cycle out of reset.
  assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("Output request right after reset.");

endmodule

bind ping_pong_sample_reorder_unit pprs_checker u_pprs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_even_i      (out_o.out_even),
  .pair_position_i (out_o.pair_position),
  .beat_end_i      (out_o.beat_end)
);
